[rtl/rpat_pkg.sv]
// Shared types, codes and sizes for the route passenger aggregation table.
package rpat_pkg;

  localparam int TABLE_ENTRIES_DEF = 256;
  localparam int MONTH_SLOTS_DEF   = 6;
  localparam int MONTH_OUTS        = 6;
  localparam int KEY_W             = 64;
  localparam int SUM_W             = 32;
  localparam int TOT_W             = 40;
  localparam int GRAND_W           = 48;
  localparam int COUNT_W           = 9;

  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  localparam logic [1:0] KIND_ROUTE   = 2'd0;
  localparam logic [1:0] KIND_ORIGIN  = 2'd1;
  localparam logic [1:0] KIND_DEST    = 2'd2;
  localparam logic [1:0] KIND_AIRLINE = 2'd3;

  localparam logic [1:0] STAT_UPDATED   = 2'd0;
  localparam logic [1:0] STAT_INSERTED  = 2'd1;
  localparam logic [1:0] STAT_FULL      = 2'd2;
  localparam logic [1:0] STAT_BAD_MONTH = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_INSERT,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic        op;
    logic [2:0]  month;
    logic [23:0] origin_code;
    logic [23:0] dest_code;
    logic [15:0] airline_code;
    logic [23:0] passengers;
    logic [1:0]  search_kind;
    logic [23:0] key_first;
    logic [23:0] key_second;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [7:0]         entry_index;
    logic               match_found;
    logic [COUNT_W-1:0] match_count;
    logic [TOT_W-1:0]   month1_total;
    logic [TOT_W-1:0]   month2_total;
    logic [TOT_W-1:0]   month3_total;
    logic [TOT_W-1:0]   month4_total;
    logic [TOT_W-1:0]   month5_total;
    logic [TOT_W-1:0]   month6_total;
    logic [GRAND_W-1:0] grand_total;
  } res_t;

  // One scanned entry handed to the search accumulator.
  typedef struct packed {
    logic vld;
    logic hit;
  } scan_t;

  typedef struct packed {
    logic [COUNT_W-1:0]                  count;
    logic [MONTH_OUTS-1:0][TOT_W-1:0]    month_tot;
    logic [GRAND_W-1:0]                  grand;
  } acc_t;

endpackage

[rtl/rpat_ram.sv]
// Generic simple dual-port RAM with registered read.
module rpat_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/rpat_accum.sv]
// Search accumulator: per-month saturating totals, row sum, grand total and match count.
module rpat_accum #(
  parameter int MONTH_SLOTS = rpat_pkg::MONTH_SLOTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                clear,
  input  rpat_pkg::scan_t                     scan,
  input  logic [MONTH_SLOTS*rpat_pkg::SUM_W-1:0] row,
  output logic                                busy,
  output rpat_pkg::acc_t                      acc
);

  localparam int SUM_W   = rpat_pkg::SUM_W;
  localparam int TOT_W   = rpat_pkg::TOT_W;
  localparam int GRAND_W = rpat_pkg::GRAND_W;
  localparam int COUNT_W = rpat_pkg::COUNT_W;
  localparam int OUTS    = rpat_pkg::MONTH_OUTS;
  localparam int ROW_W   = MONTH_SLOTS * SUM_W;
  localparam int RSUM_W  = SUM_W + $clog2(MONTH_SLOTS + 1);
  localparam int LANE_W  = TOT_W + 1;
  localparam int GSUM_W  = GRAND_W + 1;

  logic                         v1_r, v2_r;
  logic [ROW_W-1:0]             row1_r;
  logic [RSUM_W-1:0]            rsum_r, rsum_nxt;
  logic [OUTS-1:0][TOT_W-1:0]   tot_r, tot_add;
  logic [COUNT_W-1:0]           cnt_r;
  logic [GRAND_W-1:0]           grand_r;
  logic [GSUM_W-1:0]            grand_sum;

  for (genvar j = 0; j < OUTS; j++) begin : g_lane
    if (j < MONTH_SLOTS) begin : g_on
      logic [LANE_W-1:0] lane_sum;
      assign lane_sum   = {1'b0, tot_r[j]} + LANE_W'(row1_r[j*SUM_W +: SUM_W]);
      assign tot_add[j] = lane_sum[TOT_W] ? '1 : lane_sum[TOT_W-1:0];
    end else begin : g_off
      assign tot_add[j] = '0;
    end
  end

  always_comb begin
    rsum_nxt = '0;
    for (int j = 0; j < MONTH_SLOTS; j++) begin
      rsum_nxt = rsum_nxt + RSUM_W'(row1_r[j*SUM_W +: SUM_W]);
    end
  end

  assign grand_sum = {1'b0, grand_r} + GSUM_W'(rsum_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= scan.vld && scan.hit;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    row1_r <= row;
    rsum_r <= rsum_nxt;
    if (clear) begin
      tot_r   <= '0;
      cnt_r   <= '0;
      grand_r <= '0;
    end else begin
      if (v1_r) begin
        tot_r <= tot_add;
        if (cnt_r != '1) begin
          cnt_r <= cnt_r + COUNT_W'(1);
        end
      end
      if (v2_r) begin
        grand_r <= grand_sum[GRAND_W] ? '1 : grand_sum[GRAND_W-1:0];
      end
    end
  end

  assign busy          = v1_r || v2_r;
  assign acc.count     = cnt_r;
  assign acc.month_tot = tot_r;
  assign acc.grand     = grand_r;

endmodule

[rtl/rpat_ctrl.sv]
// Sequencer: key scan, read-modify-write of month rows, inserts and result formation.
module rpat_ctrl #(
  parameter int TABLE_ENTRIES = rpat_pkg::TABLE_ENTRIES_DEF,
  parameter int MONTH_SLOTS   = rpat_pkg::MONTH_SLOTS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  rpat_pkg::in_t                          in_req,
  output logic [$clog2(TABLE_ENTRIES)-1:0]       rd_addr,
  input  logic [rpat_pkg::KEY_W-1:0]             key_rdata,
  input  logic [MONTH_SLOTS*rpat_pkg::SUM_W-1:0] row_rdata,
  output logic [$clog2(TABLE_ENTRIES)-1:0]       wr_addr,
  output logic                                   key_we,
  output logic                                   row_we,
  output logic [rpat_pkg::KEY_W-1:0]             key_wdata,
  output logic [MONTH_SLOTS*rpat_pkg::SUM_W-1:0] row_wdata,
  output rpat_pkg::scan_t                        scan,
  input  logic                                   acc_busy,
  input  rpat_pkg::acc_t                         acc,
  output logic                                   out_valid,
  output rpat_pkg::res_t                         out_result
);

  localparam int IDX_W  = $clog2(TABLE_ENTRIES);
  localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
  localparam int SUM_W  = rpat_pkg::SUM_W;
  localparam int ROW_W  = MONTH_SLOTS * SUM_W;
  localparam int SLOT_W = SUM_W + 1;

  rpat_pkg::state_t state_r, state_nxt;
  rpat_pkg::in_t    req_r;
  rpat_pkg::res_t   out_r, out_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0] iss_r, iss_nxt, cnt_r, cnt_nxt;
  logic             pend_r;
  logic [IDX_W-1:0] pend_idx_r, idx_r, idx_nxt;
  logic [ROW_W-1:0] row_r, row_nxt, row_upd, row_new;
  logic [SLOT_W-1:0] slot_sum;
  logic [rpat_pkg::KEY_W-1:0] req_key;
  logic             accept, bad_month, issue, scan_done, key_hit, srch_hit, full, is_add;

  assign accept    = start && (state_r == rpat_pkg::ST_IDLE);
  assign bad_month = (in_req.month == 3'd0) || (int'(in_req.month) > MONTH_SLOTS);
  assign is_add    = (req_r.op == rpat_pkg::OP_ADD);
  assign req_key   = {req_r.origin_code, req_r.dest_code, req_r.airline_code};
  assign issue     = (state_r == rpat_pkg::ST_SCAN) && (iss_r != cnt_r);
  assign scan_done = !issue && !pend_r;
  assign key_hit   = pend_r && (key_rdata == req_key);
  assign full      = (cnt_r == CNT_W'(TABLE_ENTRIES));

  // Search match on the stored key fields.
  always_comb begin
    case (req_r.search_kind)
      rpat_pkg::KIND_ROUTE:   srch_hit = (key_rdata[63:40] == req_r.key_first) &&
                                         (key_rdata[39:16] == req_r.key_second);
      rpat_pkg::KIND_ORIGIN:  srch_hit = (key_rdata[63:40] == req_r.key_first);
      rpat_pkg::KIND_DEST:    srch_hit = (key_rdata[39:16] == req_r.key_first);
      rpat_pkg::KIND_AIRLINE: srch_hit = (key_rdata[15:0] == req_r.key_first[15:0]);
      default:                srch_hit = 1'b0;
    endcase
  end

  // Month row with the addressed slot bumped (update) or seeded (insert).
  always_comb begin
    row_upd  = row_r;
    row_new  = '0;
    slot_sum = '0;
    for (int j = 0; j < MONTH_SLOTS; j++) begin
      if ((j + 1) == int'(req_r.month)) begin
        slot_sum = {1'b0, row_r[j*SUM_W +: SUM_W]} + SLOT_W'(req_r.passengers);
        row_upd[j*SUM_W +: SUM_W] = slot_sum[SUM_W] ? '1 : slot_sum[SUM_W-1:0];
        row_new[j*SUM_W +: SUM_W] = SUM_W'(req_r.passengers);
      end
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rpat_pkg::ST_IDLE: begin
        if (accept && !(in_req.op == rpat_pkg::OP_ADD && bad_month)) begin
          state_nxt = rpat_pkg::ST_SCAN;
        end
      end
      rpat_pkg::ST_SCAN: begin
        if (is_add) begin
          if (key_hit) begin
            state_nxt = rpat_pkg::ST_UPDATE;
          end else if (scan_done) begin
            state_nxt = full ? rpat_pkg::ST_IDLE : rpat_pkg::ST_INSERT;
          end
        end else if (scan_done) begin
          state_nxt = rpat_pkg::ST_DRAIN;
        end
      end
      rpat_pkg::ST_UPDATE: state_nxt = rpat_pkg::ST_IDLE;
      rpat_pkg::ST_INSERT: state_nxt = rpat_pkg::ST_IDLE;
      rpat_pkg::ST_DRAIN: begin
        if (!acc_busy) begin
          state_nxt = rpat_pkg::ST_IDLE;
        end
      end
      default: state_nxt = rpat_pkg::ST_IDLE;
    endcase
  end

  // Outputs: memory controls, accumulator feed and the result word.
  always_comb begin
    rd_addr       = issue ? iss_r[IDX_W-1:0] : '0;
    key_we        = (state_r == rpat_pkg::ST_INSERT);
    row_we        = (state_r == rpat_pkg::ST_INSERT) || (state_r == rpat_pkg::ST_UPDATE);
    wr_addr       = (state_r == rpat_pkg::ST_UPDATE) ? idx_r : cnt_r[IDX_W-1:0];
    key_wdata     = req_key;
    row_wdata     = (state_r == rpat_pkg::ST_UPDATE) ? row_upd : row_new;
    scan.vld      = pend_r && (state_r == rpat_pkg::ST_SCAN) && !is_add;
    scan.hit      = srch_hit;
    out_valid_nxt = 1'b0;
    out_nxt       = '0;
    case (state_r)
      rpat_pkg::ST_IDLE: begin
        if (accept && in_req.op == rpat_pkg::OP_ADD && bad_month) begin
          out_valid_nxt  = 1'b1;
          out_nxt.status = rpat_pkg::STAT_BAD_MONTH;
        end
      end
      rpat_pkg::ST_SCAN: begin
        if (is_add && !key_hit && scan_done && full) begin
          out_valid_nxt  = 1'b1;
          out_nxt.status = rpat_pkg::STAT_FULL;
        end
      end
      rpat_pkg::ST_UPDATE: begin
        out_valid_nxt       = 1'b1;
        out_nxt.status      = rpat_pkg::STAT_UPDATED;
        out_nxt.entry_index = 8'(idx_r);
      end
      rpat_pkg::ST_INSERT: begin
        out_valid_nxt       = 1'b1;
        out_nxt.status      = rpat_pkg::STAT_INSERTED;
        out_nxt.entry_index = 8'(cnt_r);
      end
      rpat_pkg::ST_DRAIN: begin
        if (!acc_busy) begin
          out_valid_nxt        = 1'b1;
          out_nxt.match_found  = (acc.count != '0);
          out_nxt.match_count  = acc.count;
          out_nxt.month1_total = acc.month_tot[0];
          out_nxt.month2_total = acc.month_tot[1];
          out_nxt.month3_total = acc.month_tot[2];
          out_nxt.month4_total = acc.month_tot[3];
          out_nxt.month5_total = acc.month_tot[4];
          out_nxt.month6_total = acc.month_tot[5];
          out_nxt.grand_total  = acc.grand;
        end
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  // Counters and captured row.
  always_comb begin
    iss_nxt = iss_r;
    cnt_nxt = cnt_r;
    idx_nxt = idx_r;
    row_nxt = row_r;
    if (accept) begin
      iss_nxt = '0;
    end else if (issue) begin
      iss_nxt = iss_r + CNT_W'(1);
    end
    if (state_r == rpat_pkg::ST_SCAN && is_add && key_hit) begin
      idx_nxt = pend_idx_r;
      row_nxt = row_rdata;
    end
    if (state_r == rpat_pkg::ST_INSERT) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rpat_pkg::ST_IDLE;
      cnt_r       <= '0;
      iss_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      iss_r       <= iss_nxt;
      pend_r      <= issue;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_req;
    end
    pend_idx_r <= iss_r[IDX_W-1:0];
    idx_r      <= idx_nxt;
    row_r      <= row_nxt;
    out_r      <= out_nxt;
  end

  assign busy       = (state_r != rpat_pkg::ST_IDLE);
  assign out_valid  = out_valid_r;
  assign out_result = out_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(TABLE_ENTRIES))
    else $error("entry count above table size");

  a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
    key_we |-> !full)
    else $error("insert into a full table");

  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.status == rpat_pkg::STAT_INSERTED)
      |-> cnt_r == $past(cnt_r) + CNT_W'(1))
    else $error("insert reported without count advance");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rpat_pkg::ST_SCAN) |-> iss_r <= cnt_r)
    else $error("scan pointer past valid entries");

  a_drain_reply: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rpat_pkg::ST_DRAIN && !acc_busy) |=> out_valid_r)
    else $error("search finished without a result strobe");

endmodule

[rtl/route_passenger_aggregation_table.sv]
// Top level of the route passenger aggregation table.
//
// Drive in_req and raise start; the request is taken at a rising edge where
// start is high and busy is low. Exactly one result follows per request:
// out_valid is high for one cycle with out_result; the receiver cannot hold
// it off, so capture it on that cycle.
// An add looks up its route key over the stored entries, one per cycle from
// the key RAM; a hit does a read-modify-write of that entry's month row and a
// miss appends a new entry. A search scans all stored entries, feeding
// matching month rows into a three-stage saturating accumulator.
// A search answers once the accumulator has drained. Both RAMs share one
// read address, so the scan reads one entry a cycle.
// One request is in flight at a time; busy covers it, and the next request
// may be taken in the cycle its result is shown.
// Reset clears the entry count, so the table starts empty; RAM contents are
// not cleared and entries beyond the count are never read.
module route_passenger_aggregation_table #(
  parameter int TABLE_ENTRIES = rpat_pkg::TABLE_ENTRIES_DEF,
  parameter int MONTH_SLOTS   = rpat_pkg::MONTH_SLOTS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  rpat_pkg::in_t  in_req,
  output logic           out_valid,
  output rpat_pkg::res_t out_result
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int ROW_W = MONTH_SLOTS * rpat_pkg::SUM_W;

  logic [IDX_W-1:0]             rd_addr, wr_addr;
  logic                         key_we, row_we, acc_busy;
  logic [rpat_pkg::KEY_W-1:0]   key_wdata, key_rdata;
  logic [ROW_W-1:0]             row_wdata, row_rdata;
  rpat_pkg::scan_t              scan;
  rpat_pkg::acc_t               acc;

  // Route keys: origin, destination, airline packed into one word.
  rpat_ram #(
    .WIDTH (rpat_pkg::KEY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (wr_addr),
    .wdata (key_wdata),
    .raddr (rd_addr),
    .rdata (key_rdata)
  );

  // Month sums: one row of MONTH_SLOTS saturating counters per entry.
  rpat_ram #(
    .WIDTH (ROW_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_row_ram (
    .clk   (clk),
    .we    (row_we),
    .waddr (wr_addr),
    .wdata (row_wdata),
    .raddr (rd_addr),
    .rdata (row_rdata)
  );

  // Clear the totals as each request is taken.
  rpat_accum #(
    .MONTH_SLOTS (MONTH_SLOTS)
  ) u_accum (
    .clk   (clk),
    .rst_n (rst_n),
    .clear (start && !busy),
    .scan  (scan),
    .row   (row_rdata),
    .busy  (acc_busy),
    .acc   (acc)
  );

  rpat_ctrl #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .MONTH_SLOTS   (MONTH_SLOTS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_req     (in_req),
    .rd_addr    (rd_addr),
    .key_rdata  (key_rdata),
    .row_rdata  (row_rdata),
    .wr_addr    (wr_addr),
    .key_we     (key_we),
    .row_we     (row_we),
    .key_wdata  (key_wdata),
    .row_wdata  (row_wdata),
    .scan       (scan),
    .acc_busy   (acc_busy),
    .acc        (acc),
    .out_valid  (out_valid),
    .out_result (out_result)
  );

endmodule

[verif/route_passenger_aggregation_table_test.sv]
// Self-checking testbench for the route passenger aggregation table.
module route_passenger_aggregation_table_test;

  localparam int TABLE_N = rpat_pkg::TABLE_ENTRIES_DEF;
  localparam int MONTH_N = rpat_pkg::MONTH_SLOTS_DEF;
  localparam int MONTH_OUTS = rpat_pkg::MONTH_OUTS;
  localparam int KEY_W = rpat_pkg::KEY_W;
  localparam int SUM_W = rpat_pkg::SUM_W;
  localparam int TOT_W = rpat_pkg::TOT_W;
  localparam int GRAND_W = rpat_pkg::GRAND_W;
  localparam int COUNT_W = rpat_pkg::COUNT_W;
  localparam int POOL_N = 6;
  localparam int AIRLINE_POOL_N = 8;
  localparam logic [23:0] MAX_COUNT = 24'hFF_FFFF;
  localparam logic [23:0] ALL_ONES_CODE = 24'hFF_FFFF;
  localparam logic [15:0] ALL_ONES_AIRLINE = 16'hFFFF;
  localparam logic [63:0] SUM_MAX = (64'd1 << SUM_W) - 1;
  localparam logic [63:0] TOT_MAX = (64'd1 << TOT_W) - 1;
  localparam logic [63:0] GRAND_MAX = (64'd1 << GRAND_W) - 1;
  localparam int COUNT_MAX = (1 << COUNT_W) - 1;
  localparam int SENDER_IDLE_LIGHT = 12;
  localparam int SENDER_IDLE_HEAVY = 74;
  // Slowest request is a full-table scan; leave room for it after the last result.
  localparam int DRAIN_CYCLES = TABLE_N + 16;
  localparam int LIMIT_CYCLES = 1_500_000;

  // Mirror of the route table: predicts one result per accepted request and
  // holds the results still owed by the block, oldest first.
  class route_table_scoreboard;
    logic [KEY_W-1:0] route_key [TABLE_N];
    logic [SUM_W-1:0] slot_sum [TABLE_N][MONTH_N];
    int routes_stored;
    rpat_pkg::res_t pending_results[$];
    int errors;
    int inserts;
    int updates;
    int drops;
    int bad_months;
    int searches;
    int search_hits;
    int ceiling_hits;

    function logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b, logic [63:0] cap);
      logic [63:0] s;
      s = a + b;
      return (s > cap) ? cap : s;
    endfunction

    function rpat_pkg::res_t compute_route_result(rpat_pkg::in_t r);
      rpat_pkg::res_t res;
      logic [KEY_W-1:0] key;
      logic [63:0] month_tot [MONTH_OUTS];
      logic [63:0] grand;
      logic [63:0] summed;
      int i;
      int j;
      int idx;
      int count;
      bit hit;
      bit m;
      res = '0;
      if (r.op == rpat_pkg::OP_ADD) begin
        key = {r.origin_code, r.dest_code, r.airline_code};
        if (r.month < 1 || r.month > MONTH_N) begin
          res.status = rpat_pkg::STAT_BAD_MONTH;
          bad_months++;
          return res;
        end
        hit = 1'b0;
        idx = 0;
        for (i = 0; i < routes_stored; i++) begin
          if (!hit && route_key[i] == key) begin
            hit = 1'b1;
            idx = i;
          end
        end
        if (hit) begin
          res.status = rpat_pkg::STAT_UPDATED;
          updates++;
        end else if (routes_stored >= TABLE_N) begin
          res.status = rpat_pkg::STAT_FULL;
          drops++;
          return res;
        end else begin
          idx = routes_stored;
          route_key[idx] = key;
          for (j = 0; j < MONTH_N; j++) slot_sum[idx][j] = '0;
          routes_stored++;
          res.status = rpat_pkg::STAT_INSERTED;
          inserts++;
        end
        summed = sat_sum(64'(slot_sum[idx][r.month - 1]), 64'(r.passengers), SUM_MAX);
        if (summed == SUM_MAX) ceiling_hits++;
        slot_sum[idx][r.month - 1] = summed[SUM_W-1:0];
        res.entry_index = idx[7:0];
      end else begin
        searches++;
        for (j = 0; j < MONTH_OUTS; j++) month_tot[j] = '0;
        grand = '0;
        count = 0;
        for (i = 0; i < routes_stored; i++) begin
          m = 1'b0;
          case (r.search_kind)
            rpat_pkg::KIND_ROUTE: m = route_key[i][63:40] == r.key_first &&
                                      route_key[i][39:16] == r.key_second;
            rpat_pkg::KIND_ORIGIN: m = route_key[i][63:40] == r.key_first;
            rpat_pkg::KIND_DEST: m = route_key[i][39:16] == r.key_first;
            rpat_pkg::KIND_AIRLINE: m = route_key[i][15:0] == r.key_first[15:0];
            default: m = 1'b0;
          endcase
          if (m) begin
            count++;
            for (j = 0; j < MONTH_N; j++) begin
              if (j < MONTH_OUTS) begin
                month_tot[j] = sat_sum(month_tot[j], 64'(slot_sum[i][j]), TOT_MAX);
              end
              grand = sat_sum(grand, 64'(slot_sum[i][j]), GRAND_MAX);
            end
          end
        end
        if (count != 0) search_hits++;
        res.match_found = (count != 0);
        res.match_count = COUNT_W'((count > COUNT_MAX) ? COUNT_MAX : count);
        res.month1_total = month_tot[0][TOT_W-1:0];
        res.month2_total = month_tot[1][TOT_W-1:0];
        res.month3_total = month_tot[2][TOT_W-1:0];
        res.month4_total = month_tot[3][TOT_W-1:0];
        res.month5_total = month_tot[4][TOT_W-1:0];
        res.month6_total = month_tot[5][TOT_W-1:0];
        res.grand_total = grand[GRAND_W-1:0];
      end
      return res;
    endfunction

    function void note_request(rpat_pkg::in_t r);
      pending_results.push_back(compute_route_result(r));
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(rpat_pkg::res_t got);
      rpat_pkg::res_t want;
      if (pending_results.size() == 0) begin
        $error("result strobe with no request outstanding");
        errors++;
        return;
      end
      want = pending_results.pop_front();
      compare_field("status", 64'(want.status), 64'(got.status));
      compare_field("entry_index", 64'(want.entry_index), 64'(got.entry_index));
      compare_field("match_found", 64'(want.match_found), 64'(got.match_found));
      compare_field("match_count", 64'(want.match_count), 64'(got.match_count));
      compare_field("month1_total", 64'(want.month1_total), 64'(got.month1_total));
      compare_field("month2_total", 64'(want.month2_total), 64'(got.month2_total));
      compare_field("month3_total", 64'(want.month3_total), 64'(got.month3_total));
      compare_field("month4_total", 64'(want.month4_total), 64'(got.month4_total));
      compare_field("month5_total", 64'(want.month5_total), 64'(got.month5_total));
      compare_field("month6_total", 64'(want.month6_total), 64'(got.month6_total));
      compare_field("grand_total", 64'(want.grand_total), 64'(got.grand_total));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  rpat_pkg::in_t in_req = '0;
  logic out_valid;
  rpat_pkg::res_t out_result;

  route_table_scoreboard routes = new();

  // Small code pools so that adds hit stored routes and searches find them,
  // while the route space (plus random noise) still overflows the table.
  logic [23:0] origin_pool [POOL_N];
  logic [23:0] dest_pool [POOL_N];
  logic [15:0] airline_pool [AIRLINE_POOL_N];

  int unsigned cycle_count = 0;

  route_passenger_aggregation_table u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_req     (in_req),
    .out_valid  (out_valid),
    .out_result (out_result)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Sample the result strobe at the edge that ends its cycle; the receiver
  // never stalls, so every strobe is a delivered result.
  always @(posedge clk) begin
    if (rst_n && out_valid) routes.check_result(out_result);
  end

  // Watchdog: stop a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, routes.pending_results.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Present one request and hold it until the block takes it. Idle first
  // with probability idle_pct per cycle so start rises at random points of
  // the block's scan.
  task automatic drive_request(input rpat_pkg::in_t r, input int idle_pct);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_req <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    // Taken at this edge: predict its result now, before the table moves on.
    routes.note_request(r);
  endtask

  // Drop start and wait until every owed result has come back.
  task automatic wait_for_drain();
    start <= 1'b0;
    while (routes.pending_results.size() != 0) @(posedge clk);
  endtask

  // Add request; the search fields are ignored by the block, so fill them at random.
  function automatic rpat_pkg::in_t route_add(logic [23:0] origin, logic [23:0] dest,
                                              logic [15:0] airline, logic [2:0] month,
                                              logic [23:0] passengers);
    rpat_pkg::in_t r;
    r.op = rpat_pkg::OP_ADD;
    r.month = month;
    r.origin_code = origin;
    r.dest_code = dest;
    r.airline_code = airline;
    r.passengers = passengers;
    r.search_kind = 2'($urandom);
    r.key_first = 24'($urandom);
    r.key_second = 24'($urandom);
    return r;
  endfunction

  // Search request; the add fields are ignored, so fill them at random.
  function automatic rpat_pkg::in_t route_search(logic [1:0] kind, logic [23:0] first_key,
                                                 logic [23:0] second_key);
    rpat_pkg::in_t r;
    r.op = rpat_pkg::OP_SEARCH;
    r.month = 3'($urandom);
    r.origin_code = 24'($urandom);
    r.dest_code = 24'($urandom);
    r.airline_code = 16'($urandom);
    r.passengers = 24'($urandom);
    r.search_kind = kind;
    r.key_first = first_key;
    r.key_second = second_key;
    return r;
  endfunction

  // Mostly well-formed traffic over the code pools, with some fully random
  // routes and keys, bad months and extreme passenger counts mixed in.
  function automatic rpat_pkg::in_t random_request();
    rpat_pkg::in_t r;
    logic [191:0] noise;
    int pick;
    noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    r = noise[$bits(rpat_pkg::in_t)-1:0];
    r.op = ($urandom_range(0, 99) < 35) ? rpat_pkg::OP_SEARCH : rpat_pkg::OP_ADD;
    r.month = 3'($urandom_range(1, MONTH_N));
    if ($urandom_range(0, 99) < 8) r.month = $urandom_range(0, 1) ? 3'd7 : 3'd0;
    if ($urandom_range(0, 99) < 85) begin
      r.origin_code = origin_pool[$urandom_range(0, POOL_N - 1)];
      r.dest_code = dest_pool[$urandom_range(0, POOL_N - 1)];
      r.airline_code = airline_pool[$urandom_range(0, AIRLINE_POOL_N - 1)];
    end
    pick = $urandom_range(0, 9);
    if (pick == 0) r.passengers = '0;
    else if (pick == 1) r.passengers = MAX_COUNT;
    if ($urandom_range(0, 99) < 80) begin
      case (r.search_kind)
        rpat_pkg::KIND_ROUTE: begin
          r.key_first = origin_pool[$urandom_range(0, POOL_N - 1)];
          r.key_second = dest_pool[$urandom_range(0, POOL_N - 1)];
        end
        rpat_pkg::KIND_ORIGIN: r.key_first = origin_pool[$urandom_range(0, POOL_N - 1)];
        rpat_pkg::KIND_DEST: r.key_first = dest_pool[$urandom_range(0, POOL_N - 1)];
        rpat_pkg::KIND_AIRLINE: begin
          r.key_first[15:0] = airline_pool[$urandom_range(0, AIRLINE_POOL_N - 1)];
        end
        default: r.key_first = r.key_first;
      endcase
    end
    return r;
  endfunction

  initial begin : stimulus
    int n;
    int m;
    for (n = 0; n < POOL_N; n++) begin
      origin_pool[n] = 24'($urandom);
      dest_pool[n] = 24'($urandom);
    end
    for (n = 0; n < AIRLINE_POOL_N; n++) airline_pool[n] = 16'($urandom);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Search the empty table: no kind may match anything.
    drive_request(route_search(rpat_pkg::KIND_ROUTE, '0, '0), 0);
    drive_request(route_search(rpat_pkg::KIND_AIRLINE, ALL_ONES_CODE, ALL_ONES_CODE), 0);

    // Months 0 and 7 are flagged and must not insert the route.
    drive_request(route_add(ALL_ONES_CODE, ALL_ONES_CODE, ALL_ONES_AIRLINE, 3'd0, MAX_COUNT), 0);
    drive_request(route_add(ALL_ONES_CODE, ALL_ONES_CODE, ALL_ONES_AIRLINE, 3'd7, MAX_COUNT), 0);

    // All-zero and all-one routes at the month and count extremes; the
    // second all-one add hits the entry just inserted.
    drive_request(route_add('0, '0, '0, 3'd1, '0), 0);
    drive_request(route_add(ALL_ONES_CODE, ALL_ONES_CODE, ALL_ONES_AIRLINE, 3'd6, MAX_COUNT), 0);
    drive_request(route_add(ALL_ONES_CODE, ALL_ONES_CODE, ALL_ONES_AIRLINE, 3'd6, MAX_COUNT), 0);

    // Fill every month of one route: insert on the first, hits after.
    for (m = 1; m <= MONTH_N; m++)
      drive_request(route_add(origin_pool[1], dest_pool[1], airline_pool[1], 3'(m),
                              24'($urandom)), 0);
    // Bad month on a stored route leaves its sums alone.
    drive_request(route_add(origin_pool[1], dest_pool[1], airline_pool[1], 3'd7, MAX_COUNT), 0);

    // One search of each kind, plus an airline search whose upper key byte
    // must be ignored and a route search that should miss.
    drive_request(route_search(rpat_pkg::KIND_ROUTE, origin_pool[1], dest_pool[1]), 0);
    drive_request(route_search(rpat_pkg::KIND_ORIGIN, ALL_ONES_CODE, '0), 0);
    drive_request(route_search(rpat_pkg::KIND_DEST, '0, ALL_ONES_CODE), 0);
    drive_request(route_search(rpat_pkg::KIND_AIRLINE, 24'h5A_0000, '0), 0);
    drive_request(route_search(rpat_pkg::KIND_AIRLINE, {8'hC3, airline_pool[1]}, '0), 0);
    drive_request(route_search(rpat_pkg::KIND_ROUTE, origin_pool[1], dest_pool[2]), 0);
    wait_for_drain();

    // Pile full counts onto one month of one route until its sum pins at the ceiling.
    for (n = 0; n < 260; n++)
      drive_request(route_add(origin_pool[0], dest_pool[0], airline_pool[0], 3'd3, MAX_COUNT),
                    SENDER_IDLE_LIGHT);
    drive_request(route_search(rpat_pkg::KIND_ROUTE, origin_pool[0], dest_pool[0]),
                  SENDER_IDLE_LIGHT);

    for (n = 0; n < 380; n++) drive_request(random_request(), SENDER_IDLE_LIGHT);

    // Hold off the next request until the block has answered everything.
    wait_for_drain();

    for (n = 0; n < 195; n++) drive_request(random_request(), SENDER_IDLE_HEAVY);
    for (n = 0; n < 195; n++) drive_request(random_request(), 0);

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d adds: %0d inserted, %0d updated, %0d dropped full, %0d bad months",
             routes.inserts + routes.updates + routes.drops + routes.bad_months,
             routes.inserts, routes.updates, routes.drops, routes.bad_months);
    $display("Checked %0d searches (%0d with matches); %0d adds pinned a month sum",
             routes.searches, routes.search_hits, routes.ceiling_hits);
    if (routes.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
